// File: hw/rtl/kal_pkg.sv
// Shared types, constants and sizing helpers of the k-th ancestor engine.
package kal_pkg;

	// default geometry
	localparam int KAL_NODES  = 1024;
	localparam int KAL_LEVELS = 10;

	// fixed field widths
	localparam int NODE_W  = 10;
	localparam int STEPS_W = 20;
	localparam int CNT_W   = 21;   // holds any node count up to 2^20
	localparam int MAX_ROWS = 1 << NODE_W;

	// item opcodes
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// one jump table entry: a node number and a valid bit (clear means none)
	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node;
	} entry_t;

	// one result item
	typedef struct packed {
		logic [NODE_W-1:0] ancestor;
		logic              found;
		logic              status;
	} res_t;

	// only nodes reachable through a 10-bit number need a row
	function automatic int kal_rows(int nodes);
		return (nodes < MAX_ROWS) ? nodes : MAX_ROWS;
	endfunction

	function automatic int kal_addr_w(int nodes, int levels);
		return $clog2(kal_rows(nodes) * levels);
	endfunction

	function automatic int kal_lvl_w(int levels);
		return (levels > 1) ? $clog2(levels) : 1;
	endfunction

endpackage

// File: hw/rtl/kth_ancestor_binary_lifting.sv
// Top level of the k-th ancestor engine: stream ports, sequencer, table, result register.
//
// Items enter on s_tvalid/s_tready; s_tuser carries the opcode, s_tdata the
// node, parent, root flag and step count. Every item gives one result item on
// m_tvalid/m_tready: m_tdata holds ancestor and found, m_tuser the status bit.
// One item is worked on at a time; s_tready is high only while the sequencer
// is idle, and stays high while a finished result waits in the output register.
// Each item's path to the output register is set by the single memory read port
// and its registered data. No-ops, ignored writes and queries before build or
// out of range go straight to the result; a parent write does one table write;
// a query reads one entry per top-level jump and one per set bit of steps below
// the top level, and stops early if the climb passes a root; a build reads, for
// each of min(NODES,1024) x (LEVELS-1) entries, the entry one level down and,
// when that has a node to jump from, that node's entry one level down, then
// writes the entry.
// The next item is taken in the cycle after a result moves to the output register.
// Reset clears the built flag, the sequencer and the output valid; the table
// itself is not cleared and must be written for every node before a build.
// A stalled receiver holds the result in the output register; once the
// register is full, the next finished result waits inside the sequencer.
module kth_ancestor_binary_lifting import kal_pkg::*; #(
	parameter int NODES  = KAL_NODES,
	parameter int LEVELS = KAL_LEVELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // node[9:0], parent_node[19:10], has_parent[20], steps[40:21]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // ancestor[9:0], found[10]
	output logic        m_tuser    // status[0]
);

	localparam int DEPTH  = kal_rows(NODES) * LEVELS;
	localparam int ADDR_W = kal_addr_w(NODES, LEVELS);

	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              mem_ren;
	logic [ADDR_W-1:0] mem_raddr;
	entry_t            mem_rdata;
	logic              mem_wen;
	logic [ADDR_W-1:0] mem_waddr;
	entry_t            mem_wdata;
	logic              m_tvalid_q;
	res_t              out_q;

	kal_ctrl #(
		.NODES  (NODES),
		.LEVELS (LEVELS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_op         (op_t'(s_tuser)),
		.in_node       (s_tdata[9:0]),
		.in_parent     (s_tdata[19:10]),
		.in_has_parent (s_tdata[20]),
		.in_steps      (s_tdata[40:21]),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.mem_ren       (mem_ren),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.mem_wen       (mem_wen),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata)
	);

	kal_jump_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.ren   (mem_ren),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.wen   (mem_wen),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	// output register: loads when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_q.found, out_q.ancestor};
	assign m_tuser  = out_q.status;

endmodule

// File: hw/rtl/kal_jump_mem.sv
// Jump table memory: one write port, one registered read port.
module kal_jump_mem import kal_pkg::*; #(
	parameter int DEPTH  = KAL_NODES * KAL_LEVELS,
	parameter int ADDR_W = kal_addr_w(KAL_NODES, KAL_LEVELS)
) (
	input  logic              clk,
	input  logic              ren,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rdata,
	input  logic              wen,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/kal_ctrl.sv
// Sequencer for parent writes, level-by-level table build and ancestor climbs.
module kal_ctrl import kal_pkg::*; #(
	parameter int NODES  = KAL_NODES,
	parameter int LEVELS = KAL_LEVELS,
	localparam int ADDR_W = kal_addr_w(NODES, LEVELS)
) (
	input  logic               clk,
	input  logic               arst_n,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  op_t                in_op,
	input  logic [NODE_W-1:0]  in_node,
	input  logic [NODE_W-1:0]  in_parent,
	input  logic               in_has_parent,
	input  logic [STEPS_W-1:0] in_steps,
	// finished result
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res,
	// jump table port
	output logic               mem_ren,
	output logic [ADDR_W-1:0]  mem_raddr,
	input  entry_t             mem_rdata,
	output logic               mem_wen,
	output logic [ADDR_W-1:0]  mem_waddr,
	output entry_t             mem_wdata
);

	localparam int ROWS  = kal_rows(NODES);
	localparam int ROW_W = $clog2(ROWS);
	localparam int LVL_W = kal_lvl_w(LEVELS);
	localparam logic [LVL_W-1:0] TOP      = LVL_W'(LEVELS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_WRITE = 10'b0000000010,
		S_BRA   = 10'b0000000100,
		S_BRB   = 10'b0000001000,
		S_BWR   = 10'b0000010000,
		S_QBIG  = 10'b0000100000,
		S_QBIGW = 10'b0001000000,
		S_QBIT  = 10'b0010000000,
		S_QBITW = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t             state_q;
	logic               built_q;
	logic [ROW_W-1:0]   row_q;
	logic [LVL_W-1:0]   lvl_q;
	entry_t             e_q;
	logic [STEPS_W-1:0] big_q;
	logic [STEPS_W-1:0] k_q;
	res_t               res_q;

	logic               node_ok;
	logic               steps_ok;
	logic               parent_ok;
	logic               last_row;
	logic               last_lvl;
	logic [ROW_W-1:0]   rd_row;
	logic [LVL_W-1:0]   rd_lvl;
	logic [LVL_W-1:0]   wr_lvl;

	// entry points at a node that has a row
	function automatic logic ent_ok(entry_t e);
		return e.valid && (CNT_W'(e.node) < CNT_W'(NODES));
	endfunction

	assign node_ok   = CNT_W'(in_node) < CNT_W'(NODES);
	assign steps_ok  = CNT_W'(in_steps) < CNT_W'(NODES);
	assign parent_ok = in_has_parent && (CNT_W'(in_parent) < CNT_W'(NODES));
	assign last_row  = row_q == LAST_ROW;
	assign last_lvl  = lvl_q == TOP;

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = res_q;

	// memory port steering
	always_comb begin
		mem_ren   = 1'b0;
		mem_wen   = 1'b0;
		mem_wdata = e_q;
		rd_row    = row_q;
		rd_lvl    = LVL_W'(lvl_q - LVL_W'(1));
		wr_lvl    = lvl_q;
		unique case (state_q)
			S_WRITE: begin
				mem_wen = 1'b1;
				wr_lvl  = '0;
			end
			S_BRA: begin
				mem_ren = 1'b1;
			end
			S_BRB: begin
				rd_row = ROW_W'(mem_rdata.node);
				if (ent_ok(mem_rdata)) begin
					mem_ren = 1'b1;
				end else begin
					mem_wen   = 1'b1;
					mem_wdata = '0;
				end
			end
			S_BWR: begin
				mem_wen   = 1'b1;
				mem_wdata = mem_rdata;
			end
			S_QBIG: begin
				rd_row  = ROW_W'(e_q.node);
				rd_lvl  = TOP;
				mem_ren = (big_q != '0) && ent_ok(e_q);
			end
			S_QBIT: begin
				rd_row  = ROW_W'(e_q.node);
				rd_lvl  = lvl_q;
				mem_ren = !last_lvl && k_q[0] && ent_ok(e_q);
			end
			default: begin
			end
		endcase
	end

	assign mem_raddr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(LEVELS) + ADDR_W'(rd_lvl));
	assign mem_waddr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(LEVELS) + ADDR_W'(wr_lvl));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			built_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (in_op)
							OP_WRITE: state_q <= node_ok ? S_WRITE : S_DONE;
							OP_BUILD: begin
								if (LEVELS == 1) begin
									built_q <= 1'b1;
									state_q <= S_DONE;
								end else begin
									state_q <= S_BRA;
								end
							end
							OP_QUERY: begin
								state_q <= (built_q && node_ok && steps_ok) ? S_QBIG : S_DONE;
							end
							OP_NOP:   state_q <= S_DONE;
						endcase
					end
				end
				S_WRITE: begin
					built_q <= 1'b0;
					state_q <= S_DONE;
				end
				S_BRA: state_q <= S_BRB;
				S_BRB, S_BWR: begin
					if (state_q == S_BRB && ent_ok(mem_rdata)) begin
						state_q <= S_BWR;
					end else if (last_row && last_lvl) begin
						built_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_BRA;
					end
				end
				S_QBIG: begin
					if ((big_q != '0) && e_q.valid) begin
						if (ent_ok(e_q)) begin
							state_q <= S_QBIGW;
						end
					end else begin
						state_q <= S_QBIT;
					end
				end
				S_QBIGW: state_q <= S_QBIG;
				S_QBIT: begin
					if (!last_lvl && e_q.valid) begin
						if (k_q[0] && ent_ok(e_q)) begin
							state_q <= S_QBITW;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_QBITW: state_q <= S_QBIT;
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				res_q <= '{ancestor: '0, found: 1'b0,
					status: (in_op == OP_QUERY) && !built_q};
				big_q <= in_steps >> TOP;
				k_q   <= in_steps;
				unique case (in_op)
					OP_WRITE: begin
						row_q <= ROW_W'(in_node);
						lvl_q <= '0;
						e_q   <= parent_ok ? entry_t'{valid: 1'b1, node: in_parent}
							: entry_t'('0);
					end
					OP_BUILD: begin
						row_q <= '0;
						lvl_q <= LVL_W'(1);
					end
					OP_QUERY, OP_NOP: begin
						row_q <= ROW_W'(in_node);
						lvl_q <= '0;
						e_q   <= '{valid: 1'b1, node: in_node};
					end
				endcase
			end
			S_BRB, S_BWR: begin
				if (!(state_q == S_BRB && ent_ok(mem_rdata))) begin
					if (last_row) begin
						row_q <= '0;
						lvl_q <= LVL_W'(lvl_q + LVL_W'(1));
					end else begin
						row_q <= ROW_W'(row_q + ROW_W'(1));
					end
				end
			end
			S_QBIG: begin
				if ((big_q != '0) && e_q.valid && !ent_ok(e_q)) begin
					e_q <= '0;
				end
			end
			S_QBIGW: begin
				e_q   <= mem_rdata;
				big_q <= big_q - STEPS_W'(1);
			end
			S_QBIT: begin
				if (!last_lvl && e_q.valid) begin
					if (k_q[0]) begin
						if (!ent_ok(e_q)) begin
							e_q <= '0;
						end
					end else begin
						lvl_q <= LVL_W'(lvl_q + LVL_W'(1));
						k_q   <= k_q >> 1;
					end
				end else begin
					res_q <= '{ancestor: e_q.valid ? e_q.node : '0, found: e_q.valid,
						status: 1'b0};
				end
			end
			S_QBITW: begin
				e_q   <= mem_rdata;
				lvl_q <= LVL_W'(lvl_q + LVL_W'(1));
				k_q   <= k_q >> 1;
			end
			default: begin
			end
		endcase
	end

	// a big jump is only waited for while big jumps remain
	a_bigw_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_QBIGW |-> big_q != '0)
		else $error("big jump taken with zero count");

	// a parent write always drops the built flag
	a_write_unbuilds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE |=> !built_q)
		else $error("table still marked built after parent write");

	// a not-built answer never reports an ancestor
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_q.status) |-> (!res_q.found && res_q.ancestor == '0))
		else $error("not-built result carries an ancestor");

	// build never reads below level zero
	a_build_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BRA || state_q == S_BRB) |-> lvl_q != '0)
		else $error("build sweep at level zero");

endmodule

// File: verif/testbench.sv
// Self-checking stream testbench for the k-th ancestor engine with a binary-lifting predictor.
module testbench;
	import kal_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES     = KAL_NODES;
	localparam int LEVELS    = KAL_LEVELS;
	localparam int TOP_LVL   = LEVELS - 1;
	localparam int TAIL      = 80;    // items at the end sent with no idling
	localparam int HOLD_LEN  = 300;   // long receiver hold-off, in cycles
	localparam int RATE_SPAN = 400;   // cycles between idle-rate changes

	// one input item
	typedef struct packed {
		op_t                op;
		logic [NODE_W-1:0]  node;
		logic [NODE_W-1:0]  parent_node;
		logic               has_parent;
		logic [STEPS_W-1:0] steps;
	} lift_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;

	lift_item_t offer = '0;
	lift_item_t pending [$];
	res_t       ancestry_q [$];

	// predictor state: jump table and built flag
	entry_t lift_tab [NODES][LEVELS];
	logic   lift_ready = 1'b0;

	int accepted_cnt = 0;
	int offered_cnt  = 0;
	int results_seen = 0;
	int total_items  = 0;
	int err_cnt      = 0;
	int hold_at      = -1;

	assign s_tdata = {7'b0, offer.steps, offer.has_parent, offer.parent_node, offer.node};
	assign s_tuser = offer.op;

	kth_ancestor_binary_lifting u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one jump of 2^lvl from an entry
	function automatic entry_t hop(entry_t e, int lvl);
		if (!e.valid || int'(e.node) >= NODES)
			return '0;
		return lift_tab[e.node][lvl];
	endfunction

	// updates the predictor state and returns the expected result of an item
	function automatic res_t predict_result(lift_item_t it);
		res_t   r;
		entry_t e;
		int     big;
		r = '0;
		case (it.op)
			OP_WRITE: begin
				if (int'(it.node) < NODES) begin
					e = '0;
					if (it.has_parent && int'(it.parent_node) < NODES) begin
						e.valid = 1'b1;
						e.node  = it.parent_node;
					end
					lift_tab[it.node][0] = e;
					lift_ready = 1'b0;
				end
			end
			OP_BUILD: begin
				for (int lvl = 1; lvl < LEVELS; lvl++)
					for (int n = 0; n < NODES; n++)
						lift_tab[n][lvl] = hop(lift_tab[n][lvl-1], lvl - 1);
				lift_ready = 1'b1;
			end
			OP_QUERY: begin
				if (!lift_ready) begin
					r.status = 1'b1;
				end else if (int'(it.node) < NODES && int'(it.steps) < NODES) begin
					e.valid = 1'b1;
					e.node  = it.node;
					// whole top-level jumps first, then the low bits of steps
					big = int'(it.steps) >> TOP_LVL;
					while (big > 0 && e.valid) begin
						e = hop(e, TOP_LVL);
						big--;
					end
					for (int lvl = 0; lvl < TOP_LVL; lvl++)
						if (e.valid && it.steps[lvl])
							e = hop(e, lvl);
					if (e.valid) begin
						r.ancestor = e.node;
						r.found    = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void add_item(op_t op, int node, int par, int hasp, int steps);
		lift_item_t it;
		it.op          = op;
		it.node        = node[NODE_W-1:0];
		it.parent_node = par[NODE_W-1:0];
		it.has_parent  = hasp[0];
		it.steps       = steps[STEPS_W-1:0];
		pending.insert(pending.size(), it);
	endfunction

	// mostly short climbs, some deep ones, a few past the node count
	function automatic int pick_steps();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $urandom_range(0, 31);
		if (r < 70)
			return $urandom_range(0, NODES - 1);
		if (r < 88)
			return $urandom_range(NODES / 2, NODES - 1);
		if (r < 95)
			return $urandom_range(NODES, 2 * NODES - 1);
		return $urandom_range(0, (1 << STEPS_W) - 1);
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 8;
			default: return 30;
		endcase
	endfunction

	function automatic void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_val,
				act_val);
			err_cnt++;
		end
	endfunction

	// input acceptance and result checking
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				ancestry_q.insert(ancestry_q.size(), predict_result(offer));
				accepted_cnt++;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (ancestry_q.size() == 0) begin
					$display("%0t ns: result item with no item outstanding", $time);
					err_cnt++;
				end else begin
					want = ancestry_q.pop_front();
					check_field("ancestor", want.ancestor, m_tdata[NODE_W-1:0]);
					check_field("found", want.found, m_tdata[NODE_W]);
					check_field("status", want.status, m_tuser);
				end
			end
		end
	end

	// sender: holds an item until taken, idles in random bursts between items
	always @(negedge clk) begin
		int  tx_gap;
		int  tx_pct;
		int  tx_tick;
		logic nv;
		if (arst_n) begin
			nv = s_tvalid;
			if (tx_tick == 0)
				tx_pct = pick_pct();
			tx_tick = (tx_tick + 1) % RATE_SPAN;
			if (!s_tvalid || accepted_cnt == offered_cnt) begin
				if (tx_gap > 0) begin
					tx_gap--;
					nv = 1'b0;
				end else if (pending.size() == 0) begin
					nv = 1'b0;
				end else if (pending.size() > TAIL && $urandom_range(0, 99) < tx_pct) begin
					tx_gap = $urandom_range(1, 18) - 1;
					nv = 1'b0;
				end else begin
					offer <= pending.pop_front();
					offered_cnt++;
					nv = 1'b1;
				end
			end
			s_tvalid <= nv;
		end
	end

	// receiver: random stall bursts plus one long hold-off
	always @(negedge clk) begin
		int  rx_gap;
		int  rx_pct;
		int  rx_tick;
		int  hold_cnt;
		bit  held;
		logic rdy;
		if (arst_n) begin
			if (rx_tick == 0)
				rx_pct = pick_pct();
			rx_tick = (rx_tick + 1) % RATE_SPAN;
			if (hold_cnt > 0) begin
				hold_cnt--;
				rdy = 1'b0;
			end else if (!held && hold_at >= 0 && results_seen >= hold_at) begin
				held = 1'b1;
				hold_cnt = HOLD_LEN - 1;
				rdy = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rdy = 1'b0;
			end else if (pending.size() > TAIL && $urandom_range(0, 99) < rx_pct) begin
				rx_gap = $urandom_range(1, 18) - 1;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			m_tready <= rdy;
		end
	end

	// run limit
	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int perm [NODES];
		int par_of [NODES];
		int hasp_of [NODES];
		int j;
		int tmp;
		int r;
		int deep;
		int root;
		int nq;
		int nw;

		for (int n = 0; n < NODES; n++)
			for (int l = 0; l < LEVELS; l++)
				lift_tab[n][l] = '0;

		// queries and a no-op before any build
		add_item(OP_QUERY, 0, 0, 0, 0);
		add_item(OP_QUERY, NODES - 1, 0, 1, (1 << STEPS_W) - 1);
		add_item(OP_NOP, NODES - 1, NODES - 1, 1, (1 << STEPS_W) - 1);

		// long random chains: parent is mostly the previous node of a shuffle
		for (int i = 0; i < NODES; i++)
			perm[i] = i;
		for (int i = NODES - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		for (int i = 0; i < NODES; i++) begin
			r = $urandom_range(0, 99);
			par_of[perm[i]]  = $urandom_range(0, NODES - 1);
			hasp_of[perm[i]] = 1;
			if (i == 0 || r < 2)
				hasp_of[perm[i]] = 0;
			else if (r < 80)
				par_of[perm[i]] = perm[i-1];
			else
				par_of[perm[i]] = perm[$urandom_range(0, i - 1)];
		end
		for (int n = 0; n < NODES; n++)
			add_item(OP_WRITE, n, par_of[n], hasp_of[n], $urandom_range(0, (1 << STEPS_W) - 1));
		root = perm[0];
		deep = perm[NODES-1];
		add_item(OP_BUILD, 0, 0, 0, 0);

		// zero steps, past the root, top-level jumps, step counts at and above the node count
		add_item(OP_QUERY, root, 0, 0, 0);
		add_item(OP_QUERY, root, 0, 0, 1);
		add_item(OP_QUERY, deep, 0, 0, 1);
		add_item(OP_QUERY, deep, 0, 0, NODES / 2);
		add_item(OP_QUERY, deep, 0, 0, NODES / 2 + 1);
		add_item(OP_QUERY, deep, 0, 0, NODES - 1);
		add_item(OP_QUERY, deep, 0, 0, NODES);
		add_item(OP_QUERY, deep, 0, 0, (1 << STEPS_W) - 1);
		add_item(OP_QUERY, NODES - 1, 0, 0, 767);
		add_item(OP_BUILD, 0, 0, 0, 0);
		add_item(OP_QUERY, 0, 0, 0, 511);

		// a write after a build needs a rebuild; closing a cycle through the root
		add_item(OP_WRITE, root, deep, 1, 0);
		add_item(OP_QUERY, deep, 0, 0, 3);
		add_item(OP_WRITE, perm[1], NODES - 1, 0, 0);
		add_item(OP_WRITE, perm[1], root, 1, 0);
		add_item(OP_BUILD, 0, 0, 0, 0);
		add_item(OP_QUERY, deep, 0, 0, NODES - 1);
		add_item(OP_QUERY, root, 0, 0, 2 * NODES - 1);

		// random phases: parent rewrites, sometimes a query, a build, then a run of queries and no-ops
		for (int ep = 0; ep < 3; ep++) begin
			nw = $urandom_range(1, 20);
			for (int w = 0; w < nw; w++)
				add_item(OP_WRITE, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
					$urandom_range(0, 15) != 0, $urandom_range(0, (1 << STEPS_W) - 1));
			if ($urandom_range(0, 1))
				add_item(OP_QUERY, $urandom_range(0, NODES - 1), 0, 0, pick_steps());
			add_item(OP_BUILD, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
				$urandom_range(0, 1), $urandom_range(0, (1 << STEPS_W) - 1));
			nq = $urandom_range(40, 60);
			for (int q = 0; q < nq; q++) begin
				if (ep == 0 && q == 30)
					hold_at = pending.size();
				if ($urandom_range(0, 19) == 0)
					add_item(OP_NOP, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
						$urandom_range(0, 1), $urandom_range(0, (1 << STEPS_W) - 1));
				else
					add_item(OP_QUERY, $urandom_range(0, NODES - 1),
						$urandom_range(0, NODES - 1), $urandom_range(0, 1), pick_steps());
			end
		end
		total_items = pending.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (accepted_cnt == total_items && ancestry_q.size() == 0);
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/kal_pkg.sv
hw/rtl/kal_jump_mem.sv
hw/rtl/kal_ctrl.sv
hw/rtl/kth_ancestor_binary_lifting.sv
verif/testbench.sv
